/* hdl/phlm_pkg.sv */
// Package for the peak hold level meter: field widths, register indexes,
// register reset values and command codes.
// No dependencies.
package phlm_pkg;

  localparam int HOLD_W = 12;
  localparam int STEP_W = 10;
  localparam int FALL_W = 10;
  localparam int LEN_W  = 13;
  localparam int MS_W   = 16;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_HOLD_TIME = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FALL_STEP = 2'd1;
  localparam logic [IDX_W-1:0] CFG_FALL_TIME = 2'd2;
  localparam logic [IDX_W-1:0] CFG_METER_LEN = 2'd3;

  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 12'd400;
  localparam logic [STEP_W-1:0] FALL_STEP_RST = 10'd1;
  localparam logic [FALL_W-1:0] FALL_TIME_RST = 10'd20;
  localparam logic [LEN_W-1:0]  METER_LEN_RST = 13'd128;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

endpackage

/* hdl/phlm_if.sv */
// Valid/ready channel interfaces for the peak hold level meter: the input
// channel (command, sample, elapsed time) and the result channel.
// Depends on phlm_pkg.
interface phlm_in_if #(parameter int VALUE_W = 17);
  import phlm_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [VALUE_W-1:0] level_in;
  logic [MS_W-1:0]    elapsed_ms;

  modport source (output valid, cmd, level_in, elapsed_ms, input ready);
  modport sink   (input valid, cmd, level_in, elapsed_ms, output ready);
endinterface

interface phlm_out_if #(parameter int VALUE_W = 17);
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] level_out;
  logic [VALUE_W-1:0] peak_out;

  modport source (output valid, level_out, peak_out, input ready);
  modport sink   (input valid, level_out, peak_out, output ready);
endinterface

/* hdl/peak_hold_level_meter.sv */
// Peak hold level meter with linear fall, unsigned Q1.F fixed point.
// Depends on phlm_pkg and on the channel interfaces in phlm_if.sv.

// A level sample (cmd 0) updates the displayed level and the held peak and
// passes from acceptance until the block is ready again through accept,
// execute and result write. A tick (cmd 1) that leaves the hold countdown
// positive passes through the same states. A tick that lets the peak fall
// passes through accept, execute, one division step per quotient bit, the
// fall update and the result write.
// The fall amount fall_step*elapsed*2^F / (fall_time*length) comes from a
// restoring divider that yields one quotient bit per cycle over the full
// quotient width. The result sits in an output register, so a new item is
// accepted while the previous result still waits; an item only waits at its
// result write when that register is still full. Configuration writes are
// taken at any time but are meant to be done while the block is idle.
// Registers that read as zero for the fall period or the meter length count
// as one.
module peak_hold_level_meter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_en,
  input  logic [phlm_pkg::IDX_W-1:0] cfg_index,
  input  logic [phlm_pkg::CFG_W-1:0] cfg_data,
  phlm_in_if.sink                 in_ch,
  phlm_out_if.source              out_ch
);
  import phlm_pkg::*;

  // Value width, divisor width, product width and dividend width.
  localparam int VW    = FRACTION_BITS + 1;
  localparam int DW    = FALL_W + LEN_W;
  localparam int PW    = STEP_W + MS_W;
  localparam int NW    = PW + FRACTION_BITS;
  localparam int CNT_W = $clog2(NW);
  localparam logic [VW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_FALL  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [HOLD_W-1:0] hold_time_ms;
  logic [STEP_W-1:0] fall_step;
  logic [FALL_W-1:0] fall_time_ms;
  logic [LEN_W-1:0]  meter_length;

  // Meter state.
  logic [VW-1:0]     level_reg;
  logic [VW-1:0]     peak_reg;
  logic [HOLD_W-1:0] hold_countdown;

  // Captured input item.
  logic              cmd_q;
  logic [VW-1:0]     lv_q;
  logic [MS_W-1:0]   ms_q;

  // Divider: num shifts the dividend out at the top and the quotient in at
  // the bottom, so after NW steps it holds the quotient.
  logic [NW-1:0]     num;
  logic [DW-1:0]     divisor;
  logic [DW-1:0]     rem;
  logic [CNT_W-1:0]  cnt;

  // Output register.
  logic              out_valid;
  logic [VW-1:0]     level_out_q;
  logic [VW-1:0]     peak_out_q;

  logic [FALL_W-1:0] ft_eff;
  logic [LEN_W-1:0]  ml_eff;
  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_diff;
  logic              rem_ge;
  logic [VW-1:0]     fallen;
  logic [VW-1:0]     peak_fall_next;
  logic              out_free;
  logic              out_load;

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = out_valid;
  assign out_ch.level_out = level_out_q;
  assign out_ch.peak_out  = peak_out_q;
  assign out_free         = !out_valid || out_ch.ready;
  assign out_load         = (state == ST_WRITE) && out_free;

  assign ft_eff = (fall_time_ms == '0) ? FALL_W'(1) : fall_time_ms;
  assign ml_eff = (meter_length == '0) ? LEN_W'(1) : meter_length;

  // One restoring division step.
  assign rem_sh   = {rem, num[NW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});

  // A fall at least as large as the peak empties it; a peak above full scale is
  // brought back to full scale after the fall, even when nothing fell.
  always_comb begin
    if (num >= NW'(peak_reg)) begin
      fallen = '0;
    end else begin
      fallen = peak_reg - num[VW-1:0];
    end
    peak_fall_next = (fallen > ONE) ? ONE : fallen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms <= HOLD_TIME_RST;
      fall_step    <= FALL_STEP_RST;
      fall_time_ms <= FALL_TIME_RST;
      meter_length <= METER_LEN_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_HOLD_TIME: hold_time_ms <= cfg_data[HOLD_W-1:0];
        CFG_FALL_STEP: fall_step    <= cfg_data[STEP_W-1:0];
        CFG_FALL_TIME: fall_time_ms <= cfg_data[FALL_W-1:0];
        CFG_METER_LEN: meter_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register loads at the result write and empties when the
  // result is taken; a load and a take in the same cycle leave it full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      level_out_q <= level_reg;
      peak_out_q  <= peak_reg;
      out_valid   <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      level_reg      <= '0;
      peak_reg       <= '0;
      hold_countdown <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cmd_q <= in_ch.cmd;
            lv_q  <= in_ch.level_in;
            ms_q  <= in_ch.elapsed_ms;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd_q == CMD_SAMPLE) begin
            level_reg <= (lv_q > ONE) ? ONE : lv_q;
            if (lv_q != '0) begin
              if (lv_q > peak_reg) begin
                peak_reg       <= lv_q;
                hold_countdown <= hold_time_ms;
              end
            end else begin
              peak_reg <= '0;
            end
            state <= ST_WRITE;
          end else if (ms_q < MS_W'(hold_countdown)) begin
            // Still holding: only the countdown moves.
            hold_countdown <= hold_countdown - ms_q[HOLD_W-1:0];
            state          <= ST_WRITE;
          end else begin
            hold_countdown <= '0;
            divisor        <= DW'(ft_eff) * DW'(ml_eff);
            num            <= {PW'(fall_step) * PW'(ms_q), {FRACTION_BITS{1'b0}}};
            rem            <= '0;
            cnt            <= CNT_W'(NW - 1);
            state          <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          num <= {num[NW-2:0], rem_ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_FALL;
          end
        end
        ST_FALL: begin
          peak_reg <= peak_fall_next;
          state    <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The displayed level never exceeds full scale.
  a_level_clamped: assert property (@(posedge clk) disable iff (rst)
    level_reg <= ONE)
    else $error("displayed level above full scale");

  // An accepted item always goes to execution next.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_EXEC))
    else $error("accepted item did not reach execution");

  // The last division step hands over to the fall update.
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == '0) |=> (state == ST_FALL))
    else $error("division did not end in the fall update");

  // After a fall the peak sits within full scale.
  a_fall_sat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FALL) |=> (peak_reg <= ONE))
    else $error("peak above full scale after fall");
`endif

endmodule
